// ===== design/tmw_pkg.sv =====
// ----------------------------------------------------------------------------
// Trimmed-mean window filter package
// Sample width and the control record that travels with each pipeline stage.
// ----------------------------------------------------------------------------
package tmw_pkg;

	localparam int SAMPLE_W = 16;

	// Per-stage control: item present, and oldest window slot was nonzero
	typedef struct packed {
		logic valid;
		logic full;
	} stage_ctl_t;

endpackage

// ===== design/tmw_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// One slot of the sample window; takes its neighbor's value on each shift.
// ----------------------------------------------------------------------------
module tmw_cell
	import tmw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  logic [SAMPLE_W-1:0] d,
	output logic [SAMPLE_W-1:0] q
);

	logic [SAMPLE_W-1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule

// ===== design/tmw_reduce_stage.sv =====
// ----------------------------------------------------------------------------
// Reduction stage
// One registered level of the sum / max / min tree: combines node pairs.
// ----------------------------------------------------------------------------
module tmw_reduce_stage
	import tmw_pkg::*;
#(
	parameter int N_IN  = 8,
	parameter int SUM_W = 19
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  stage_ctl_t          ctl_in,
	input  logic [SUM_W-1:0]    sum_in [0:N_IN-1],
	input  logic [SAMPLE_W-1:0] max_in [0:N_IN-1],
	input  logic [SAMPLE_W-1:0] min_in [0:N_IN-1],
	output stage_ctl_t          ctl_out,
	output logic [SUM_W-1:0]    sum_out [0:N_IN/2-1],
	output logic [SAMPLE_W-1:0] max_out [0:N_IN/2-1],
	output logic [SAMPLE_W-1:0] min_out [0:N_IN/2-1]
);

	localparam int N_OUT = N_IN / 2;

	stage_ctl_t          ctl_q;
	logic [SUM_W-1:0]    sum_q [0:N_OUT-1];
	logic [SAMPLE_W-1:0] max_q [0:N_OUT-1];
	logic [SAMPLE_W-1:0] min_q [0:N_OUT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_OUT; i++) begin
				sum_q[i] <= sum_in[2*i] + sum_in[2*i+1];
				max_q[i] <= (max_in[2*i] > max_in[2*i+1]) ? max_in[2*i] : max_in[2*i+1];
				min_q[i] <= (min_in[2*i] < min_in[2*i+1]) ? min_in[2*i] : min_in[2*i+1];
			end
		end
	end

	assign ctl_out = ctl_q;
	assign sum_out = sum_q;
	assign max_out = max_q;
	assign min_out = min_q;

endmodule

// ===== design/tmw_divide.sv =====
// ----------------------------------------------------------------------------
// Trim and divide
// Removes max and min from the sum, then divides by a constant through an
// exact reciprocal multiply. The second register is the output register.
// ----------------------------------------------------------------------------
module tmw_divide
	import tmw_pkg::*;
#(
	parameter int DIV   = 5,
	parameter int SUM_W = 19
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  stage_ctl_t          ctl_in,
	input  logic [SUM_W-1:0]    sum_in,
	input  logic [SAMPLE_W-1:0] max_in,
	input  logic [SAMPLE_W-1:0] min_in,
	output stage_ctl_t          ctl_out,
	output logic [SAMPLE_W-1:0] quotient
);

	// Round-up reciprocal with SUM_W + clog2(DIV) fraction bits is exact
	// for every dividend below 2**SUM_W.
	localparam int SH    = SUM_W + $clog2(DIV);
	localparam int MW    = SH + 1;
	localparam int PW    = SUM_W + MW;
	localparam logic [MW-1:0] RECIP = MW'(((longint'(1) << SH) + DIV - 1) / DIV);

	stage_ctl_t       ctl_s1;
	logic [SUM_W-1:0] trim_s1;
	stage_ctl_t       ctl_s2;
	logic [PW-1:0]    prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trim_s1 <= sum_in - SUM_W'(max_in) - SUM_W'(min_in);
			prod_s2 <= PW'(trim_s1) * PW'(RECIP);
		end
	end

	assign ctl_out  = ctl_s2;
	// Hold zero while the oldest window slot of this result was zero
	assign quotient = ctl_s2.full ? prod_s2[SH +: SAMPLE_W] : '0;

endmodule

// ===== design/trimmed_mean_window_filter.sv =====
// ----------------------------------------------------------------------------
// Trimmed-mean window filter
// Moving window of samples reduced to the mean without its max and min.
// ----------------------------------------------------------------------------
// Takes one sample per cycle and returns one result per sample, in order.
// Samples shift through a row of WINDOW cells; the window is reduced by a
// registered pairwise sum/max/min tree of clog2(WINDOW) levels, followed by
// a trim stage and a reciprocal multiply by 1/(WINDOW-2). Each taken sample
// passes the window cells, each tree level, then the trim and output registers.
// The whole pipeline holds while a result waits on result_ready,
// so sample_ready follows result_ready whenever the output register is full.
// ready_res is low and trimmed_mean is zero while the oldest slot is zero.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter
	import tmw_pkg::*;
#(
	parameter int WINDOW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [SAMPLE_W-1:0] trimmed_mean,
	output logic                ready_res
);

	localparam int LEVELS = $clog2(WINDOW);
	localparam int LEAVES = 1 << LEVELS;
	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);

	logic                advance;
	logic                take;
	logic                win_valid_q;
	logic [SAMPLE_W-1:0] slot [0:WINDOW-1];

	logic [SUM_W-1:0]    sum_n [1:2*LEAVES-1];
	logic [SAMPLE_W-1:0] max_n [1:2*LEAVES-1];
	logic [SAMPLE_W-1:0] min_n [1:2*LEAVES-1];
	stage_ctl_t          ctl_n [0:LEVELS];
	stage_ctl_t          ctl_out;

	assign advance      = !result_valid || result_ready;
	assign sample_ready = advance;
	assign take         = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
		end else if (advance) begin
			win_valid_q <= take;
		end
	end

	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		tmw_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (take),
			.d      ((k == 0) ? sample : slot[(k == 0) ? 0 : k-1]),
			.q      (slot[k])
		);
	end

	// Leaves: window slots, padded with neutral entries
	for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
		if (k < WINDOW) begin : g_slot
			assign sum_n[LEAVES+k] = SUM_W'(slot[k]);
			assign max_n[LEAVES+k] = slot[k];
			assign min_n[LEAVES+k] = slot[k];
		end else begin : g_pad
			assign sum_n[LEAVES+k] = '0;
			assign max_n[LEAVES+k] = '0;
			assign min_n[LEAVES+k] = '1;
		end
	end

	assign ctl_n[0] = '{valid: win_valid_q, full: (slot[WINDOW-1] != '0)};

	for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_level
		localparam int N_OUT = LEAVES >> lv;
		tmw_reduce_stage #(
			.N_IN  (2*N_OUT),
			.SUM_W (SUM_W)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (advance),
			.ctl_in  (ctl_n[lv-1]),
			.sum_in  (sum_n[2*N_OUT +: 2*N_OUT]),
			.max_in  (max_n[2*N_OUT +: 2*N_OUT]),
			.min_in  (min_n[2*N_OUT +: 2*N_OUT]),
			.ctl_out (ctl_n[lv]),
			.sum_out (sum_n[N_OUT +: N_OUT]),
			.max_out (max_n[N_OUT +: N_OUT]),
			.min_out (min_n[N_OUT +: N_OUT])
		);
	end

	tmw_divide #(
		.DIV   (WINDOW - 2),
		.SUM_W (SUM_W)
	) u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.ctl_in   (ctl_n[LEVELS]),
		.sum_in   (sum_n[1]),
		.max_in   (max_n[1]),
		.min_in   (min_n[1]),
		.ctl_out  (ctl_out),
		.quotient (trimmed_mean)
	);

	assign result_valid = ctl_out.valid;
	assign ready_res    = ctl_out.full;

endmodule
